// ----- hdl/spq_pkg.sv -----
`default_nettype none
package spq_pkg;

  localparam int ID_W             = 16;
  localparam int RANK_W           = 16;
  localparam int DEFAULT_CAPACITY = 64;

  typedef enum logic [1:0] {
    ACT_ENTER  = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LIST   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    KIND_EMPTY   = 2'd0,
    KIND_REMOVED = 2'd1,
    KIND_LISTED  = 2'd2,
    KIND_FULL    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [ID_W-1:0]   entry_id;
    logic [RANK_W-1:0] entry_rank;
  } in_item_t;

  typedef struct packed {
    kind_t           kind;
    logic [ID_W-1:0] result_id;
    logic            last;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [RANK_W-1:0] rank;
  } entry_t;

  typedef enum logic [1:0] {
    RD_PTR    = 2'd0,
    RD_PTR_M1 = 2'd1,
    RD_PTR_M2 = 2'd2
  } rd_sel_t;

  typedef enum logic {
    WR_NEW   = 1'b0,
    WR_SHIFT = 1'b1
  } wr_sel_t;

  typedef struct packed {
    logic    load_item;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    ptr_load;
    logic    ptr_clear;
    logic    ptr_dec;
    logic    ptr_inc;
    logic    count_inc;
    logic    pop;
    logic    out_load;
    kind_t   out_kind;
    logic    out_last;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic ptr_zero;
    logic ptr_one;
    logic ptr_last;
    logic shift_needed;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ----- hdl/spq_ram.sv -----
`default_nettype none
module spq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/spq_datapath.sv -----
`default_nettype none
module spq_datapath #(
  parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire spq_pkg::in_item_t item,
  input  wire spq_pkg::cmd_t     cmd,
  output spq_pkg::status_t       status,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output spq_pkg::out_item_t     result
);
  import spq_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int DEPTH = 1 << AW;
  localparam int CW    = $clog2(CAPACITY + 1);

  in_item_t        item_q;
  logic [AW-1:0]   head;
  logic [AW-1:0]   ptr;
  logic [CW-1:0]   count;
  logic [AW-1:0]   rd_off;
  logic [AW-1:0]   raddr;
  logic [AW-1:0]   waddr;
  entry_t          wdata;
  entry_t          rdata;
  logic [ID_W-1:0] out_id;

  always_comb begin
    case (cmd.rd_sel)
      RD_PTR:    rd_off = ptr;
      RD_PTR_M1: rd_off = ptr - AW'(1);
      RD_PTR_M2: rd_off = ptr - AW'(2);
      default:   rd_off = ptr;
    endcase
  end

  assign raddr = head + rd_off;
  assign waddr = head + ptr;

  always_comb begin
    case (cmd.wr_sel)
      WR_SHIFT: wdata = rdata;
      default:  wdata = '{id: item_q.entry_id, rank: item_q.entry_rank};
    endcase
  end

  spq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      ptr   <= '0;
    end else begin
      if (cmd.count_inc) begin
        count <= count + CW'(1);
      end else if (cmd.pop) begin
        count <= count - CW'(1);
        head  <= head + AW'(1);
      end
      if (cmd.ptr_load) begin
        ptr <= count[AW-1:0];
      end else if (cmd.ptr_clear) begin
        ptr <= '0;
      end else if (cmd.ptr_dec) begin
        ptr <= ptr - AW'(1);
      end else if (cmd.ptr_inc) begin
        ptr <= ptr + AW'(1);
      end
    end
  end

  always_comb begin
    case (cmd.out_kind)
      KIND_REMOVED, KIND_LISTED: out_id = rdata.id;
      default:                   out_id = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.kind      <= cmd.out_kind;
      result.result_id <= out_id;
      result.last      <= cmd.out_last;
    end
  end

  assign status.empty        = (count == '0);
  assign status.full         = (count == CW'(CAPACITY));
  assign status.ptr_zero     = (ptr == '0);
  assign status.ptr_one      = (ptr == AW'(1));
  assign status.ptr_last     = ((CW'(ptr) + CW'(1)) == count);
  assign status.shift_needed = (rdata.rank > item_q.entry_rank);
  assign status.out_free     = !result_valid || result_ready;

endmodule
`default_nettype wire

// ----- hdl/spq_ctrl.sv -----
`default_nettype none
module spq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  input  wire logic [1:0]       item_action,
  output logic                  item_ready,
  input  wire spq_pkg::status_t status,
  output spq_pkg::cmd_t         cmd
);
  import spq_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    INS_START,
    INS_CMP,
    REM_RD,
    REM_OUT,
    LST_RD,
    LST_OUT,
    RES_OUT
  } state_t;

  state_t state;
  state_t state_next;
  kind_t  res_kind;
  kind_t  res_kind_next;

  assign item_ready = (state == IDLE);

  always_comb begin
    cmd           = '0;
    state_next    = state;
    res_kind_next = res_kind;
    case (state)
      IDLE: begin
        if (item_valid) begin
          cmd.load_item = 1'b1;
          case (item_action)
            ACT_ENTER: begin
              if (status.full) begin
                res_kind_next = KIND_FULL;
                state_next    = RES_OUT;
              end else begin
                cmd.ptr_load = 1'b1;
                state_next   = INS_START;
              end
            end
            ACT_REMOVE: begin
              if (status.empty) begin
                res_kind_next = KIND_EMPTY;
                state_next    = RES_OUT;
              end else begin
                cmd.ptr_clear = 1'b1;
                state_next    = REM_RD;
              end
            end
            ACT_LIST: begin
              if (status.empty) begin
                res_kind_next = KIND_EMPTY;
                state_next    = RES_OUT;
              end else begin
                cmd.ptr_clear = 1'b1;
                state_next    = LST_RD;
              end
            end
            default: state_next = IDLE;
          endcase
        end
      end
      INS_START: begin
        if (status.ptr_zero) begin
          cmd.wr_en     = 1'b1;
          cmd.wr_sel    = WR_NEW;
          cmd.count_inc = 1'b1;
          state_next    = IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PTR_M1;
          state_next = INS_CMP;
        end
      end
      INS_CMP: begin
        cmd.wr_en = 1'b1;
        if (status.shift_needed) begin
          cmd.wr_sel  = WR_SHIFT;
          cmd.ptr_dec = 1'b1;
          if (status.ptr_one) begin
            state_next = INS_START;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_PTR_M2;
          end
        end else begin
          cmd.wr_sel    = WR_NEW;
          cmd.count_inc = 1'b1;
          state_next    = IDLE;
        end
      end
      REM_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_PTR;
        state_next = REM_OUT;
      end
      REM_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_REMOVED;
          cmd.out_last = 1'b1;
          cmd.pop      = 1'b1;
          state_next   = IDLE;
        end
      end
      LST_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_PTR;
        state_next = LST_OUT;
      end
      LST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_LISTED;
          cmd.out_last = status.ptr_last;
          if (status.ptr_last) begin
            state_next = IDLE;
          end else begin
            cmd.ptr_inc = 1'b1;
            state_next  = LST_RD;
          end
        end
      end
      RES_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = res_kind;
          cmd.out_last = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      res_kind <= KIND_EMPTY;
    end else begin
      state    <= state_next;
      res_kind <= res_kind_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sorted_priority_queue.sv -----
`default_nettype none
// channel  | valid         | ready         | payload
// item     | item_valid    | item_ready    | item   (action, entry_id, entry_rank)
// result   | result_valid  | result_ready  | result (kind, result_id, last)
//
// one item at a time; item_ready is high only while the controller is idle
// enter: shifts each entry of higher rank up from the tail, then writes the new entry
// remove: reads and returns the head; list: each id in turn; empty or full: a bare answer
// result register holds while result_ready is low; the sequencer waits on it
// rst is synchronous and empties the queue; store contents are not cleared
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire spq_pkg::in_item_t  item,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output spq_pkg::out_item_t      result
);
  import spq_pkg::*;

  cmd_t    cmd;
  status_t status;

  spq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_action (item.action),
    .item_ready  (item_ready),
    .status      (status),
    .cmd         (cmd)
  );

  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire
